// File: sv/csvds_pkg.sv
// ----------------------------------------------------------------------------
// csvds_pkg: shared types and constants of the CSV delimiter sniffer
// Widths, register indexes, mode codes and the lane control struct.
// ----------------------------------------------------------------------------
package csvds_pkg;

  localparam int COUNT_WIDTH    = 16;
  localparam int NUM_CANDIDATES = 4;
  localparam int CAND_REGS      = 4;
  localparam int BYTE_WIDTH     = 8;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int IDX_WIDTH      = 2;

  localparam logic [1:0] MODE_CHAR = 2'd0;
  localparam logic [1:0] MODE_EOL  = 2'd1;
  localparam logic [1:0] MODE_EOF  = 2'd2;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_CAND_ZERO  = 3'd0,
    REG_CAND_ONE   = 3'd1,
    REG_CAND_TWO   = 3'd2,
    REG_CAND_THREE = 3'd3,
    REG_QUOTE      = 3'd4
  } cfg_reg_e;

  localparam logic [BYTE_WIDTH-1:0] RST_CAND_ZERO  = 8'd44;
  localparam logic [BYTE_WIDTH-1:0] RST_CAND_ONE   = 8'd46;
  localparam logic [BYTE_WIDTH-1:0] RST_CAND_TWO   = 8'd32;
  localparam logic [BYTE_WIDTH-1:0] RST_CAND_THREE = 8'd59;
  localparam logic [BYTE_WIDTH-1:0] RST_QUOTE      = 8'd34;

  typedef struct packed {
    logic take_char;
    logic end_line;
    logic clear;
    logic first_line;
  } lane_ctl_t;

endpackage

// File: sv/csvds_lane.sv
// ----------------------------------------------------------------------------
// csvds_lane: quote tracking and separator counting for one candidate
// Follows quoted fields of the current line, counts separators outside them,
// and checks each finished line against the first line's count.
// ----------------------------------------------------------------------------
module csvds_lane (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  csvds_pkg::lane_ctl_t             ctl_i,
  input  logic [csvds_pkg::BYTE_WIDTH-1:0] char_i,
  input  logic [csvds_pkg::BYTE_WIDTH-1:0] sep_i,
  input  logic [csvds_pkg::BYTE_WIDTH-1:0] quote_i,
  output logic                             valid_o
);
  import csvds_pkg::*;

  typedef enum logic [3:0] {
    Q_OUT  = 4'b0001,
    Q_IN   = 4'b0010,
    Q_PEND = 4'b0100,
    Q_FAIL = 4'b1000
  } quote_e;

  quote_e                 state_q, state_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [COUNT_WIDTH-1:0] first_q, first_d;
  logic                   valid_q, valid_d;
  logic [COUNT_WIDTH-1:0] line_n;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic                   valid_eol;
  logic                   is_quote;
  logic                   is_sep;

  assign is_quote  = (char_i == quote_i);
  assign is_sep    = (char_i == sep_i);
  assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
  assign line_n    = (state_q == Q_OUT || state_q == Q_PEND) ? count_q : '0;

  always_comb begin
    valid_eol = valid_q;
    if (ctl_i.end_line && !ctl_i.first_line && valid_q) begin
      if (first_q != line_n || line_n == '0) begin
        valid_eol = 1'b0;
      end
    end
  end

  assign valid_o = valid_eol;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    first_d = first_q;
    valid_d = valid_q;
    if (ctl_i.clear) begin
      state_d = Q_OUT;
      count_d = '0;
      first_d = '0;
      valid_d = 1'b1;
    end else if (ctl_i.end_line) begin
      if (ctl_i.first_line) begin
        first_d = line_n;
      end
      valid_d = valid_eol;
      state_d = Q_OUT;
      count_d = '0;
    end else if (ctl_i.take_char) begin
      unique case (state_q)
        Q_OUT: begin
          if (is_quote) begin
            state_d = Q_IN;
          end else if (is_sep) begin
            count_d = count_inc;
          end
        end
        Q_IN: begin
          if (is_quote) begin
            state_d = Q_PEND;
          end
        end
        Q_PEND: begin
          if (is_quote) begin
            state_d = Q_IN;
          end else if (is_sep) begin
            state_d = Q_OUT;
            count_d = count_inc;
          end else begin
            state_d = Q_FAIL;
          end
        end
        Q_FAIL: begin
          state_d = Q_FAIL;
        end
        default: begin
          state_d = Q_FAIL;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Q_OUT;
      count_q <= '0;
      first_q <= '0;
      valid_q <= 1'b1;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      first_q <= first_d;
      valid_q <= valid_d;
    end
  end

endmodule

// File: sv/csv_delimiter_sniffer.sv
// ----------------------------------------------------------------------------
// csv_delimiter_sniffer: picks the separator that splits every line alike
// A request is held in the input register; an end of file then leaves its
// result in the output register.
// Throughput: one request per cycle, but an end of file waits for a stalled result.
// Reset clears the stream state and loads the default candidate bytes.
// ----------------------------------------------------------------------------
module csv_delimiter_sniffer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          mode_i,
  input  logic [csvds_pkg::BYTE_WIDTH-1:0]    char_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                found_o,
  output logic [csvds_pkg::IDX_WIDTH-1:0]     chosen_index_o,
  output logic [csvds_pkg::BYTE_WIDTH-1:0]    chosen_byte_o,
  input  logic                                cfg_we_i,
  input  logic [csvds_pkg::CFG_IDX_WIDTH-1:0] cfg_index_i,
  input  logic [csvds_pkg::BYTE_WIDTH-1:0]    cfg_data_i
);
  import csvds_pkg::*;

  logic [BYTE_WIDTH-1:0] cand_q [CAND_REGS];
  logic [BYTE_WIDTH-1:0] quote_q;

  logic                  in_vld_q, in_vld_d;
  logic [1:0]            mode_q;
  logic [BYTE_WIDTH-1:0] char_q;
  logic                  accept;
  logic                  hold;
  logic                  fire;
  logic                  fire_char;
  logic                  fire_eol;
  logic                  fire_eof;

  logic                  awaiting_first_q, awaiting_first_d;
  logic                  line_busy_q, line_busy_d;
  lane_ctl_t             lane_ctl;
  logic [NUM_CANDIDATES-1:0] lane_valid;

  logic                  out_vld_q, out_vld_d;
  logic                  found_q;
  logic [IDX_WIDTH-1:0]  index_q;
  logic [BYTE_WIDTH-1:0] byte_q;
  logic                  pick_found;
  logic [IDX_WIDTH-1:0]  pick_index;
  logic [BYTE_WIDTH-1:0] pick_byte;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q[0] <= RST_CAND_ZERO;
      cand_q[1] <= RST_CAND_ONE;
      cand_q[2] <= RST_CAND_TWO;
      cand_q[3] <= RST_CAND_THREE;
      quote_q   <= RST_QUOTE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CAND_ZERO:  cand_q[0] <= cfg_data_i;
        REG_CAND_ONE:   cand_q[1] <= cfg_data_i;
        REG_CAND_TWO:   cand_q[2] <= cfg_data_i;
        REG_CAND_THREE: cand_q[3] <= cfg_data_i;
        REG_QUOTE:      quote_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Input register. Only an end of file waits for a stalled result.
  assign hold       = (mode_q == MODE_EOF) && out_vld_q && out_stall_i;
  assign in_stall_o = in_vld_q && hold;
  assign accept     = in_valid_i && !in_stall_o;
  assign fire       = in_vld_q && !hold;
  assign fire_char  = fire && (mode_q == MODE_CHAR);
  assign fire_eol   = fire && (mode_q == MODE_EOL);
  assign fire_eof   = fire && (mode_q == MODE_EOF);

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      char_q <= char_byte_i;
    end
  end

  // Line tracking shared by all lanes.
  always_comb begin
    lane_ctl.take_char  = fire_char;
    lane_ctl.end_line   = fire_eol || (fire_eof && line_busy_q);
    lane_ctl.clear      = fire_eof;
    lane_ctl.first_line = awaiting_first_q;
  end

  always_comb begin
    awaiting_first_d = awaiting_first_q;
    line_busy_d      = line_busy_q;
    if (fire_char) begin
      line_busy_d = 1'b1;
    end else if (fire_eol) begin
      awaiting_first_d = 1'b0;
      line_busy_d      = 1'b0;
    end else if (fire_eof) begin
      awaiting_first_d = 1'b1;
      line_busy_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_first_q <= 1'b1;
      line_busy_q      <= 1'b0;
    end else begin
      awaiting_first_q <= awaiting_first_d;
      line_busy_q      <= line_busy_d;
    end
  end

  for (genvar g = 0; g < NUM_CANDIDATES; g++) begin : g_lane
    localparam int RegIdx = g % CAND_REGS;
    csvds_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (lane_ctl),
      .char_i  (char_q),
      .sep_i   (cand_q[RegIdx]),
      .quote_i (quote_q),
      .valid_o (lane_valid[g])
    );
  end

  // The lowest valid candidate wins.
  always_comb begin
    pick_found = 1'b0;
    pick_index = '0;
    pick_byte  = '0;
    for (int i = NUM_CANDIDATES - 1; i >= 0; i--) begin
      if (lane_valid[i]) begin
        pick_found = 1'b1;
        pick_index = IDX_WIDTH'(i);
        pick_byte  = cand_q[i % CAND_REGS];
      end
    end
  end

  // Result register.
  always_comb begin
    out_vld_d = out_vld_q;
    if (fire_eof) begin
      out_vld_d = 1'b1;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_eof) begin
      found_q <= pick_found;
      index_q <= pick_index;
      byte_q  <= pick_byte;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign found_o        = found_q;
  assign chosen_index_o = index_q;
  assign chosen_byte_o  = byte_q;

  // A new result only ever follows an end of file leaving the input register.
  a_result_from_eof : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(fire_eof))
    else $error("result appeared without an end of file");

  // A missing separator reports index and byte as zero.
  a_none_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !found_q) |-> (index_q == '0 && byte_q == '0))
    else $error("no candidate found but index or byte is nonzero");

  // The input side stalls only behind a pending end of file and a stalled result.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && mode_q == MODE_EOF && out_vld_q && out_stall_i))
    else $error("input stalled without cause");

  // After an end of file the stream starts over at the first line.
  a_eof_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_eof |=> (awaiting_first_q && !line_busy_q))
    else $error("stream state not restored after end of file");

endmodule
